@@ design/mcmn_pkg.sv @@
// ----------------------------------------------------------------------------
// mcmn_pkg
// Shared types and constants for the mean-centering, max-abs scaling block.
// ----------------------------------------------------------------------------
package mcmn_pkg;

    localparam int MAX_POINTS_DEF  = 1024;
    localparam int MAX_DIMS_DEF    = 16;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int DIMCNT_W   = 5;
    localparam int NORM_W     = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_COUNT   = CFG_IDX_W'(1);

    localparam logic MODE_LOAD    = 1'b0;
    localparam logic MODE_REQUEST = 1'b1;

    typedef enum logic [3:0] {
        ST_SETTLE,
        ST_LOAD,
        ST_MEAN_START,
        ST_MEAN_WAIT,
        ST_SCAN,
        ST_DRAIN,
        ST_IDLE,
        ST_RD_DEV,
        ST_RD_DIV
    } state_t;

    typedef struct packed {
        logic restart;
        logic load_wr;
        logic idx_clr;
        logic idx_adv;
        logic j_clr;
        logic j_adv;
        logic mean_start;
        logic mean_wr;
        logic max_clr;
        logic scan_issue;
        logic rd_issue;
        logic norm_start;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic cfg_hit;
        logic idx_last;
        logic j_last;
        logic div_done;
        logic out_free;
    } status_t;

endpackage

@@ design/mcmn_divider.sv @@
// ----------------------------------------------------------------------------
// mcmn_divider
// Restoring divider, one quotient bit per cycle. The quotient must fit in
// QB bits, so the remainder starts from the numerator's upper bits.
// ----------------------------------------------------------------------------
module mcmn_divider #(
    parameter int NW  = 42,
    parameter int DVW = 26,
    parameter int QB  = 24
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           start,
    input  logic [NW-1:0]  numer,
    input  logic [DVW-1:0] denom,
    output logic           done,
    output logic [QB-1:0]  quot
);

    localparam int CW = (QB > 1) ? $clog2(QB) : 1;

    logic [NW-1:0]  rem_reg;
    logic [NW-1:0]  rem_next;
    logic [QB-1:0]  nq_reg;
    logic [QB-1:0]  nq_next;
    logic [DVW-1:0] den_reg;
    logic [CW-1:0]  cnt_reg;
    logic           busy_reg;
    logic           done_reg;
    logic [NW-1:0]  trial;

    always_comb begin
        trial = {rem_reg[NW-2:0], nq_reg[QB-1]};
        if (trial >= NW'(den_reg)) begin
            rem_next = trial - NW'(den_reg);
            nq_next  = {nq_reg[QB-2:0], 1'b1};
        end else begin
            rem_next = trial;
            nq_next  = {nq_reg[QB-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + CW'(1);
            if (cnt_reg == CW'(QB - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= numer >> QB;
            nq_reg  <= numer[QB-1:0];
            den_reg <= denom;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            nq_reg  <= nq_next;
        end
    end

    assign done = done_reg;
    assign quot = nq_reg;

endmodule

@@ design/mcmn_datapath.sv @@
// ----------------------------------------------------------------------------
// mcmn_datapath
// Sample memory, per-dimension sums and means, max deviation tracking,
// shared divider and the output register.
// ----------------------------------------------------------------------------
module mcmn_datapath #(
    parameter int MAX_POINTS  = 1024,
    parameter int MAX_DIMS    = 16,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  mcmn_pkg::cmd_t                      cmd,
    output mcmn_pkg::status_t                   status,
    input  logic                                cfg_valid,
    input  logic [mcmn_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mcmn_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic signed [SAMPLE_BITS-1:0]       s_sample,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [mcmn_pkg::NORM_W-1:0]  m_normalized,
    output logic                                m_last,
    output logic                                m_degenerate
);
    import mcmn_pkg::*;

    localparam int SB    = SAMPLE_BITS;
    localparam int TOT   = MAX_POINTS * MAX_DIMS;
    localparam int AW    = $clog2(TOT);
    localparam int TW    = $clog2(TOT + 1);
    localparam int PW    = $clog2(MAX_POINTS + 1);
    localparam int DW    = $clog2(MAX_DIMS + 1);
    localparam int DIW   = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int SUMW  = SB + $clog2(MAX_POINTS);
    localparam int MW    = SB + 9;
    localparam int DEVW  = SB + 10;
    localparam int MAGW  = SB + 9;
    localparam int QB    = SB + 8;
    localparam int NW_M  = SUMW + 10;
    localparam int NW_N  = MAGW + 17;
    localparam int NW    = (NW_M > NW_N) ? NW_M : NW_N;
    localparam int DVW_M = PW + 1;
    localparam int DVW_N = MAGW + 1;
    localparam int DVW   = (DVW_M > DVW_N) ? DVW_M : DVW_N;

    // configuration
    logic [CFG_DATA_W-1:0] pc_reg;
    logic [DIMCNT_W-1:0]   dc_reg;
    logic [PW-1:0]         p_eff;
    logic [DW-1:0]         d_eff;
    logic [TW-1:0]         last_idx_reg;
    logic                  cfg_hit;

    assign cfg_hit = cfg_valid && (cfg_index == CFG_POINT_COUNT || cfg_index == CFG_DIM_COUNT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= CFG_DATA_W'(1);
            dc_reg <= DIMCNT_W'(1);
        end else if (cfg_valid) begin
            if (cfg_index == CFG_POINT_COUNT) begin
                pc_reg <= cfg_data;
            end else if (cfg_index == CFG_DIM_COUNT) begin
                dc_reg <= cfg_data[DIMCNT_W-1:0];
            end
        end
    end

    always_comb begin
        if (pc_reg == '0) begin
            p_eff = PW'(1);
        end else if (32'(pc_reg) > 32'(MAX_POINTS)) begin
            p_eff = PW'(MAX_POINTS);
        end else begin
            p_eff = PW'(pc_reg);
        end
        if (dc_reg == '0) begin
            d_eff = DW'(1);
        end else if (32'(dc_reg) > 32'(MAX_DIMS)) begin
            d_eff = DW'(MAX_DIMS);
        end else begin
            d_eff = DW'(dc_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_idx_reg <= '0;
        end else begin
            last_idx_reg <= TW'((TW + DW)'(p_eff) * (TW + DW)'(d_eff) - (TW + DW)'(1));
        end
    end

    // indices
    logic [TW-1:0]  idx_reg;
    logic [DIW-1:0] col_reg;
    logic [DIW-1:0] j_reg;
    logic           col_wrap;
    logic           j_last;

    assign col_wrap = (DW'(col_reg) == d_eff - DW'(1));
    assign j_last   = (DW'(j_reg) == d_eff - DW'(1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
            col_reg <= '0;
            j_reg   <= '0;
        end else begin
            if (cmd.restart || cmd.idx_clr) begin
                idx_reg <= '0;
                col_reg <= '0;
            end else if (cmd.idx_adv) begin
                idx_reg <= idx_reg + TW'(1);
                col_reg <= col_wrap ? '0 : col_reg + DIW'(1);
            end
            if (cmd.restart || cmd.j_clr) begin
                j_reg <= '0;
            end else if (cmd.j_adv) begin
                j_reg <= j_reg + DIW'(1);
            end
        end
    end

    // sample memory
    logic signed [SB-1:0] mem [TOT];
    logic signed [SB-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_wr) begin
            mem[idx_reg[AW-1:0]] <= s_sample;
        end
        if (cmd.scan_issue || cmd.rd_issue) begin
            rdata_reg <= mem[idx_reg[AW-1:0]];
        end
    end

    // per-dimension sums, cleared through valid bits
    logic signed [SUMW-1:0] sums [MAX_DIMS];
    logic [MAX_DIMS-1:0]    sum_vld_reg;
    logic signed [SUMW-1:0] sum_col;
    logic signed [SUMW-1:0] sum_j;
    logic [SUMW-1:0]        sum_mag;

    assign sum_col = sum_vld_reg[col_reg] ? sums[col_reg] : '0;
    assign sum_j   = sum_vld_reg[j_reg] ? sums[j_reg] : '0;
    assign sum_mag = sum_j[SUMW-1] ? SUMW'(-sum_j) : SUMW'(sum_j);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_vld_reg <= '0;
        end else if (cmd.restart) begin
            sum_vld_reg <= '0;
        end else if (cmd.load_wr) begin
            sum_vld_reg[col_reg] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_wr) begin
            sums[col_reg] <= sum_col + SUMW'(s_sample);
        end
    end

    // means
    logic signed [MW-1:0] means [MAX_DIMS];
    logic signed [MW-1:0] mean_q_reg;
    logic                 mean_neg_reg;
    logic [QB-1:0]        quot;

    always_ff @(posedge aclk) begin
        if (cmd.mean_start) begin
            mean_neg_reg <= sum_j[SUMW-1];
        end
        if (cmd.mean_wr) begin
            means[j_reg] <= mean_neg_reg ? -MW'(quot) : MW'(quot);
        end
        if (cmd.scan_issue || cmd.rd_issue) begin
            mean_q_reg <= means[col_reg];
        end
    end

    // deviation and max tracking
    logic signed [DEVW-1:0] dev;
    logic [MAGW-1:0]        dev_mag;
    logic [MAGW-1:0]        max_reg;
    logic                   scan_v_reg;

    assign dev     = (DEVW'(rdata_reg) <<< 8) - DEVW'(mean_q_reg);
    assign dev_mag = dev[DEVW-1] ? MAGW'(-dev) : MAGW'(dev);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_v_reg <= 1'b0;
            max_reg    <= '0;
        end else begin
            scan_v_reg <= cmd.scan_issue;
            if (cmd.max_clr) begin
                max_reg <= '0;
            end else if (scan_v_reg && dev_mag > max_reg) begin
                max_reg <= dev_mag;
            end
        end
    end

    // shared divider
    logic           div_start;
    logic [NW-1:0]  div_numer;
    logic [DVW-1:0] div_denom;
    logic           div_done;
    logic           dev_neg_reg;

    assign div_start = cmd.mean_start || cmd.norm_start;

    always_comb begin
        if (cmd.mean_start) begin
            div_numer = (NW'(sum_mag) << 9) + NW'(p_eff);
            div_denom = DVW'({p_eff, 1'b0});
        end else begin
            div_numer = (NW'(dev_mag) << 16) + NW'(max_reg);
            div_denom = DVW'({max_reg, 1'b0});
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.norm_start) begin
            dev_neg_reg <= dev[DEVW-1];
        end
    end

    mcmn_divider #(
        .NW  (NW),
        .DVW (DVW),
        .QB  (QB)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .numer   (div_numer),
        .denom   (div_denom),
        .done    (div_done),
        .quot    (quot)
    );

    // result shaping and output register
    logic [16:0]          q_clip;
    logic [16:0]          q_neg;
    logic [NORM_W-1:0]    norm_val;
    logic                 degen;
    logic                 m_valid_reg;
    logic [NORM_W-1:0]    norm_reg;
    logic                 last_reg;
    logic                 degen_reg;

    assign degen = (max_reg == '0);

    always_comb begin
        q_clip = (quot > QB'(32768)) ? 17'd32768 : 17'(quot);
        q_neg  = 17'd0 - q_clip;
        if (degen) begin
            norm_val = '0;
        end else if (dev_neg_reg) begin
            norm_val = q_neg[NORM_W-1:0];
        end else if (quot > QB'(32767)) begin
            norm_val = NORM_W'(32767);
        end else begin
            norm_val = quot[NORM_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            norm_reg  <= norm_val;
            last_reg  <= (idx_reg == last_idx_reg);
            degen_reg <= degen;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_normalized = norm_reg;
    assign m_last       = last_reg;
    assign m_degenerate = degen_reg;

    always_comb begin
        status.cfg_hit  = cfg_hit;
        status.idx_last = (idx_reg == last_idx_reg);
        status.j_last   = j_last;
        status.div_done = div_done;
        status.out_free = !m_valid_reg || m_ready;
    end

endmodule

@@ design/mcmn_ctrl.sv @@
// ----------------------------------------------------------------------------
// mcmn_ctrl
// Phase sequencer: load, per-dimension mean division, max scan, readout.
// ----------------------------------------------------------------------------
module mcmn_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_mode,
    output logic              s_ready,
    input  mcmn_pkg::status_t status,
    output mcmn_pkg::cmd_t    cmd
);
    import mcmn_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_SETTLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_SETTLE: begin
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                s_ready = 1'b1;
                // drop requests while loading
                if (accept && s_mode == MODE_LOAD) begin
                    cmd.load_wr = 1'b1;
                    if (status.idx_last) begin
                        cmd.idx_clr = 1'b1;
                        cmd.j_clr   = 1'b1;
                        state_next  = ST_MEAN_START;
                    end else begin
                        cmd.idx_adv = 1'b1;
                    end
                end
            end
            ST_MEAN_START: begin
                cmd.mean_start = 1'b1;
                state_next     = ST_MEAN_WAIT;
            end
            ST_MEAN_WAIT: begin
                if (status.div_done) begin
                    cmd.mean_wr = 1'b1;
                    if (status.j_last) begin
                        cmd.max_clr = 1'b1;
                        state_next  = ST_SCAN;
                    end else begin
                        cmd.j_adv  = 1'b1;
                        state_next = ST_MEAN_START;
                    end
                end
            end
            ST_SCAN: begin
                cmd.scan_issue = 1'b1;
                if (status.idx_last) begin
                    cmd.idx_clr = 1'b1;
                    state_next  = ST_DRAIN;
                end else begin
                    cmd.idx_adv = 1'b1;
                end
            end
            ST_DRAIN: begin
                state_next = ST_IDLE;
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                // drop loads during readout
                if (accept && s_mode == MODE_REQUEST) begin
                    cmd.rd_issue = 1'b1;
                    state_next   = ST_RD_DEV;
                end
            end
            ST_RD_DEV: begin
                cmd.norm_start = 1'b1;
                state_next     = ST_RD_DIV;
            end
            ST_RD_DIV: begin
                if (status.div_done && status.out_free) begin
                    cmd.out_load = 1'b1;
                    if (status.idx_last) begin
                        cmd.restart = 1'b1;
                        state_next  = ST_LOAD;
                    end else begin
                        cmd.idx_adv = 1'b1;
                        state_next  = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_SETTLE;
            end
        endcase
        if (status.cfg_hit) begin
            cmd.restart = 1'b1;
            state_next  = ST_SETTLE;
        end
    end

endmodule

@@ design/mean_center_maxabs_normalize.sv @@
// ----------------------------------------------------------------------------
// mean_center_maxabs_normalize
// Loads a point set, centers each dimension on its mean and returns each
// deviation scaled by the largest absolute deviation as signed Q1.15.
// ----------------------------------------------------------------------------
// Loading takes one sample per cycle (single sample memory write port).
// After the last sample, input is held through the mean division for each
// dimension and the max scan. A request holds input until the bit-serial
// divider is done and its result is loaded into the output register.
// Reset: point_count and dim_count to 1, phase settle then loading; no clearing pass.
// A write to a known register restarts the set and holds input through the settle state.
module mean_center_maxabs_normalize #(
    parameter int MAX_POINTS  = mcmn_pkg::MAX_POINTS_DEF,
    parameter int MAX_DIMS    = mcmn_pkg::MAX_DIMS_DEF,
    parameter int SAMPLE_BITS = mcmn_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mcmn_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mcmn_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_mode,
    input  logic signed [SAMPLE_BITS-1:0]       s_sample,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [mcmn_pkg::NORM_W-1:0]  m_normalized,
    output logic                                m_last,
    output logic                                m_degenerate
);
    import mcmn_pkg::*;

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    mcmn_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_mode  (s_mode),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    mcmn_datapath #(
        .MAX_POINTS  (MAX_POINTS),
        .MAX_DIMS    (MAX_DIMS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_sample     (s_sample),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_normalized (m_normalized),
        .m_last       (m_last),
        .m_degenerate (m_degenerate)
    );

endmodule

@@ design/mcmn_checker.sv @@
// ----------------------------------------------------------------------------
// mcmn_checker
// Port-level checks for the mean-centering, max-abs scaling block.
// ----------------------------------------------------------------------------
module mcmn_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               cfg_valid,
    input logic                               cfg_ready,
    input logic [mcmn_pkg::CFG_IDX_W-1:0]     cfg_index,
    input logic                               s_ready,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic signed [mcmn_pkg::NORM_W-1:0] m_normalized,
    input logic                               m_degenerate
);
    import mcmn_pkg::*;

    // configuration is always taken
    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_ready)
        else $error("cfg_ready low");

    // a write to a known register holds input for the settle cycle
    a_cfg_settle: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_valid && cfg_ready &&
         (cfg_index == CFG_POINT_COUNT || cfg_index == CFG_DIM_COUNT)) |=> !s_ready)
        else $error("input taken right after a register write");

    // degenerate set gives zero results
    a_degen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_degenerate) |-> (m_normalized == '0))
        else $error("degenerate result not zero");

    // result holds until taken
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_normalized)))
        else $error("result dropped or changed while stalled");

endmodule

bind mean_center_maxabs_normalize mcmn_checker u_mcmn_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_normalized (m_normalized),
    .m_degenerate (m_degenerate)
);
